### hdl/ffha_pkg.sv
package ffha_pkg;

    localparam int REQ_W     = 16;
    localparam int OFF_W     = 12;
    localparam int STATUS_W  = 3;
    localparam int LBYTES_W  = 12;
    localparam int LCHUNKS_W = 9;
    localparam int WANT_W    = REQ_W - 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 40;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_A_SPLIT,
        S_F_RD,
        S_F_EV,
        S_M_RD,
        S_M_EV,
        S_M_NRD,
        S_M_NEV,
        S_DONE
    } state_t;

endpackage

### hdl/first_fit_heap_allocator.sv
// Operation: an allocate reads and then evaluates each chunk header it walks, and may write a split
// header at the end; every chunk spans at least two granules of the G = HEAP_BYTES/8. A free walks
// likewise and then runs a merge pass over the heap, reading each header and its free neighbour.
// Throughput: one transaction at a time, set by the single header memory read port.
// Reset: rst_n is asynchronous and active low; it empties the counters and the output register
// and marks the whole heap as one free chunk without touching the header memory.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // request_bytes [15:0], free_offset [27:16], zero fill [31:28]
    input  logic [S_DATA_W-1:0] s_tdata,
    // op [0]
    input  logic [0:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status [2:0], payload_offset [14:3], live_bytes [26:15], live_chunks [35:27],
    // zero fill [39:36]
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int G  = HEAP_BYTES / 8;
    localparam int GW = $clog2(G);
    localparam int PW = GW + 1;
    localparam int HW = GW + 1;
    localparam int AW = (PW + 3 > OFF_W) ? PW + 3 : OFF_W;
    localparam logic [PW-1:0]     G_P       = PW'(G);
    localparam logic [WANT_W:0]   MAX_WANT  = (WANT_W + 1)'(G - 1);
    localparam logic [HW-1:0]     RESET_HDR = {1'b0, GW'(G - 1)};

    logic [HW-1:0] mem [G];
    logic [HW-1:0] rd_raw;
    logic          rd_zero_q;

    state_t                 state_reg, state_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [PW-1:0]          nxt_reg, nxt_next;
    logic [GW-1:0]          cur_size_reg, cur_size_next;
    logic [WANT_W-1:0]      want_reg, want_next;
    logic [OFF_W-1:0]       off_reg, off_next;
    logic [PW-1:0]          split_addr_reg, split_addr_next;
    logic [GW-1:0]          split_size_reg, split_size_next;
    status_t                res_status_reg, res_status_next;
    logic [OFF_W-1:0]       res_payload_reg, res_payload_next;
    logic [LBYTES_W-1:0]    live_bytes_reg, live_bytes_next;
    logic [LCHUNKS_W-1:0]   live_chunks_reg, live_chunks_next;
    logic                   hdr0_valid_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic                   rd_en;
    logic [GW-1:0]          rd_addr;
    logic                   wr_en;
    logic [GW-1:0]          wr_addr;
    logic [HW-1:0]          wr_data;

    logic [HW-1:0]          hdr_rd;
    logic                   hdr_used;
    logic [GW-1:0]          hdr_size;
    logic [PW-1:0]          pos_inc;
    logic [AW-1:0]          pos_bytes;
    logic [AW-1:0]          size_bytes;
    logic [PW-1:0]          pos_skip;
    logic [REQ_W:0]         req_round;
    logic [WANT_W-1:0]      want_in;
    logic [PW-1:0]          merged_p;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw    <= mem[rd_addr];
            rd_zero_q <= (rd_addr == '0);
        end
    end

    // Granule 0 holds the whole free heap until it is first written.
    assign hdr_rd     = (rd_zero_q && !hdr0_valid_reg) ? RESET_HDR : rd_raw;
    assign hdr_used   = hdr_rd[GW];
    assign hdr_size   = hdr_rd[GW-1:0];
    assign pos_inc    = pos_reg + PW'(1);
    assign pos_bytes  = AW'({pos_inc, 3'b000});
    assign size_bytes = AW'({hdr_size, 3'b000});
    assign pos_skip   = pos_inc + PW'(hdr_size);
    assign req_round  = (REQ_W + 1)'(s_tdata[REQ_W-1:0]) + (REQ_W + 1)'(7);
    assign want_in    = req_round[REQ_W:3];
    assign merged_p   = PW'(cur_size_reg) + PW'(1) + PW'(hdr_size);

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        nxt_next         = nxt_reg;
        cur_size_next    = cur_size_reg;
        want_next        = want_reg;
        off_next         = off_reg;
        split_addr_next  = split_addr_reg;
        split_size_next  = split_size_reg;
        res_status_next  = res_status_reg;
        res_payload_next = res_payload_reg;
        live_bytes_next  = live_bytes_reg;
        live_chunks_next = live_chunks_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        rd_en            = 1'b0;
        rd_addr          = pos_reg[GW-1:0];
        wr_en            = 1'b0;
        wr_addr          = pos_reg[GW-1:0];
        wr_data          = hdr_rd;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_payload_next = '0;
                    pos_next         = '0;
                    if (s_tuser[0] == OP_ALLOC)
                    begin
                        want_next = want_in;
                        if (s_tdata[REQ_W-1:0] == '0)
                        begin
                            res_status_next = ST_ZERO;
                            state_next      = S_DONE;
                        end
                        else if ({1'b0, want_in} > MAX_WANT)
                        begin
                            res_status_next = ST_TOO_LARGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        off_next = s_tdata[REQ_W+OFF_W-1:REQ_W];
                        if (s_tdata[REQ_W+OFF_W-1:REQ_W] == '0)
                        begin
                            res_status_next = ST_NOT_ALLOC;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD:
            begin
                if (pos_reg >= G_P)
                begin
                    res_status_next = ST_NO_FIT;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_A_EV;
                end
            end
            S_A_EV:
            begin
                if (!hdr_used && (WANT_W'(hdr_size) >= want_reg))
                begin
                    wr_en            = 1'b1;
                    res_status_next  = ST_OK;
                    res_payload_next = pos_bytes[OFF_W-1:0];
                    live_chunks_next = live_chunks_reg + LCHUNKS_W'(1);
                    if ((WANT_W + 1)'(hdr_size) >= (WANT_W + 1)'(want_reg) + (WANT_W + 1)'(2))
                    begin
                        wr_data         = {1'b1, want_reg[GW-1:0]};
                        split_addr_next = pos_inc + PW'(want_reg);
                        split_size_next = hdr_size - want_reg[GW-1:0] - GW'(1);
                        live_bytes_next = live_bytes_reg
                                          + LBYTES_W'({want_reg[GW-1:0], 3'b000});
                        state_next      = S_A_SPLIT;
                    end
                    else
                    begin
                        wr_data         = {1'b1, hdr_size};
                        live_bytes_next = live_bytes_reg + size_bytes[LBYTES_W-1:0];
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    pos_next   = pos_skip;
                    state_next = S_A_RD;
                end
            end
            S_A_SPLIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = split_addr_reg[GW-1:0];
                wr_data    = {1'b0, split_size_reg};
                state_next = S_DONE;
            end
            S_F_RD:
            begin
                if (pos_reg >= G_P)
                begin
                    res_status_next = ST_NOT_ALLOC;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_F_EV;
                end
            end
            S_F_EV:
            begin
                if (pos_bytes == AW'(off_reg))
                begin
                    if (hdr_used)
                    begin
                        wr_en            = 1'b1;
                        wr_data          = {1'b0, hdr_size};
                        live_bytes_next  = live_bytes_reg - size_bytes[LBYTES_W-1:0];
                        live_chunks_next = live_chunks_reg - LCHUNKS_W'(1);
                        pos_next         = '0;
                        state_next       = S_M_RD;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_ALLOC;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    pos_next   = pos_skip;
                    state_next = S_F_RD;
                end
            end
            S_M_RD:
            begin
                if (pos_reg >= G_P)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_M_EV;
                end
            end
            S_M_EV:
            begin
                cur_size_next = hdr_size;
                if (hdr_used)
                begin
                    pos_next   = pos_skip;
                    state_next = S_M_RD;
                end
                else
                begin
                    nxt_next   = pos_skip;
                    state_next = S_M_NRD;
                end
            end
            S_M_NRD:
            begin
                if (nxt_reg >= G_P)
                begin
                    pos_next   = nxt_reg;
                    state_next = S_M_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = nxt_reg[GW-1:0];
                    state_next = S_M_NEV;
                end
            end
            S_M_NEV:
            begin
                if (!hdr_used)
                begin
                    wr_en         = 1'b1;
                    wr_data       = {1'b0, merged_p[GW-1:0]};
                    cur_size_next = merged_p[GW-1:0];
                    nxt_next      = pos_inc + PW'(merged_p[GW-1:0]);
                    state_next    = S_M_NRD;
                end
                else
                begin
                    pos_next   = nxt_reg;
                    state_next = S_M_RD;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({live_chunks_reg, live_bytes_reg,
                                               res_payload_reg, res_status_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pos_reg         <= '0;
            nxt_reg         <= '0;
            cur_size_reg    <= '0;
            want_reg        <= '0;
            off_reg         <= '0;
            split_addr_reg  <= '0;
            split_size_reg  <= '0;
            res_status_reg  <= ST_OK;
            res_payload_reg <= '0;
            live_bytes_reg  <= '0;
            live_chunks_reg <= '0;
            hdr0_valid_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            nxt_reg         <= nxt_next;
            cur_size_reg    <= cur_size_next;
            want_reg        <= want_next;
            off_reg         <= off_next;
            split_addr_reg  <= split_addr_next;
            split_size_reg  <= split_size_next;
            res_status_reg  <= res_status_next;
            res_payload_reg <= res_payload_next;
            live_bytes_reg  <= live_bytes_next;
            live_chunks_reg <= live_chunks_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tdata_reg     <= m_tdata_next;
            if (wr_en && (wr_addr == '0))
            begin
                hdr0_valid_reg <= 1'b1;
            end
        end
    end

endmodule

### hdl/ffha_checker.sv
module ffha_checker
    import ffha_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [0:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A result that waits must hold still until its transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only a successful allocate grants a payload offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[14:3] == '0))
        else $error("payload offset given with an error status");

    // Granted payloads lie on granule boundaries.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:3] == 3'b000))
        else $error("unaligned payload offset");

    // The block only becomes busy by taking a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("block went busy without a request");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

### test/tb_first_fit_heap_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int HEAP_BYTES   = 4096;
    localparam int GRANULES     = HEAP_BYTES / 8;
    localparam int ROWS         = 24;
    localparam int RANDOM_ITEMS = 556;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 300;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 3200;

    typedef struct packed {
        status_t               status;
        logic [OFF_W-1:0]      payload;
        logic [LBYTES_W-1:0]   lbytes;
        logic [LCHUNKS_W-1:0]  lchunks;
    } heap_result_t;

    typedef struct packed {
        logic                  op;
        logic [REQ_W-1:0]      req;
        logic [OFF_W-1:0]      off;
        logic                  typed;
        heap_result_t          res;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Shadow of the heap: one header per granule.
    bit                  chunk_used [GRANULES];
    int                  chunk_gran [GRANULES];
    int                  live_byte_total;
    int                  live_chunk_total;

    heap_result_t        pending_results [$];
    int                  mismatch_count;
    int                  results_seen;
    int                  items_sent;

    stim_row_t           directed_rows [ROWS];

    first_fit_heap_allocator #(
        .HEAP_BYTES(HEAP_BYTES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic heap_result_t heap_apply(logic op, logic [REQ_W-1:0] req,
                                                logic [OFF_W-1:0] off);
        heap_result_t r;
        int           want;
        int           pos;
        int           nxt;
        int           size;
        bit           done;
        r.status  = ST_OK;
        r.payload = '0;
        pos       = 0;
        done      = 1'b0;
        if (op == OP_ALLOC)
        begin
            if (req == '0)
                r.status = ST_ZERO;
            else
            begin
                want = (int'(req) + 7) / 8;
                if (want > GRANULES - 1)
                    r.status = ST_TOO_LARGE;
                else
                begin
                    while (pos < GRANULES && !done)
                    begin
                        size = chunk_gran[pos];
                        if (!chunk_used[pos] && size >= want)
                        begin
                            if (size - want >= 2)
                            begin
                                chunk_used[pos + 1 + want] = 1'b0;
                                chunk_gran[pos + 1 + want] = size - want - 1;
                                size = want;
                            end
                            chunk_used[pos] = 1'b1;
                            chunk_gran[pos] = size;
                            live_byte_total += size * 8;
                            live_chunk_total++;
                            r.payload = OFF_W'((pos + 1) * 8);
                            done = 1'b1;
                        end
                        else
                            pos += 1 + size;
                    end
                    if (!done)
                        r.status = ST_NO_FIT;
                end
            end
        end
        else
        begin
            r.status = ST_NOT_ALLOC;
            if (off != '0)
            begin
                while (pos < GRANULES && !done)
                begin
                    size = chunk_gran[pos];
                    if ((pos + 1) * 8 == int'(off))
                    begin
                        done = 1'b1;
                        if (chunk_used[pos])
                        begin
                            chunk_used[pos] = 1'b0;
                            live_byte_total -= size * 8;
                            live_chunk_total--;
                            r.status = ST_OK;
                            // Coalesce every run of neighbouring free chunks.
                            pos = 0;
                            while (pos < GRANULES)
                            begin
                                if (!chunk_used[pos])
                                begin
                                    nxt = pos + 1 + chunk_gran[pos];
                                    while (nxt < GRANULES && !chunk_used[nxt])
                                    begin
                                        chunk_gran[pos] += 1 + chunk_gran[nxt];
                                        nxt = pos + 1 + chunk_gran[pos];
                                    end
                                end
                                pos += 1 + chunk_gran[pos];
                            end
                        end
                    end
                    else
                        pos += 1 + size;
                end
            end
        end
        r.lbytes  = LBYTES_W'(live_byte_total);
        r.lchunks = LCHUNKS_W'(live_chunk_total);
        return r;
    endfunction

    function automatic logic [OFF_W-1:0] pick_chunk(bit want_used);
        int offsets [$];
        int pos;
        pos = 0;
        while (pos < GRANULES)
        begin
            if (chunk_used[pos] == want_used)
                offsets.push_back((pos + 1) * 8);
            pos += 1 + chunk_gran[pos];
        end
        if (offsets.size() == 0)
            return '0;
        return OFF_W'(offsets[$urandom_range(0, offsets.size() - 1)]);
    endfunction

    task automatic send_item(logic op, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off,
                             logic typed, heap_result_t typed_res);
        int           gap;
        heap_result_t res;
        gap = ((items_sent / 40) % 4 == 1) ? 0 : $urandom_range(0, 9);
        items_sent++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, off, req};
        do
            @(posedge clk);
        while (!s_tready);
        res = heap_apply(op, req, off);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Result side: checks every transaction and stalls at random.
    initial
    begin
        heap_result_t observed;
        heap_result_t wanted;
        int           wait_left;
        wait_left      = 0;
        mismatch_count = 0;
        results_seen   = 0;
        m_tready      <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                observed.status  = status_t'(m_tdata[2:0]);
                observed.payload = m_tdata[14:3];
                observed.lbytes  = m_tdata[26:15];
                observed.lchunks = m_tdata[35:27];
                if (pending_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("Unexpected result: status %0d payload %0d bytes %0d chunks %0d",
                                 observed.status, observed.payload, observed.lbytes,
                                 observed.lchunks);
                    mismatch_count++;
                end
                else
                begin
                    wanted = pending_results.pop_front();
                    if (observed.status !== wanted.status || observed.payload !== wanted.payload
                        || observed.lbytes !== wanted.lbytes
                        || observed.lchunks !== wanted.lchunks)
                    begin
                        if (mismatch_count < 10)
                            $display("Result %0d: expected status %0d payload %0d bytes %0d chunks %0d, got status %0d payload %0d bytes %0d chunks %0d",
                                     results_seen, wanted.status, wanted.payload, wanted.lbytes,
                                     wanted.lchunks, observed.status, observed.payload,
                                     observed.lbytes, observed.lchunks);
                        mismatch_count++;
                    end
                end
                results_seen++;
                wait_left = ((results_seen / 40) % 3 == 0) ? 0 : $urandom_range(0, 9);
                if (results_seen == HOLD_AT)
                    wait_left = HOLD_CYCLES;
            end
            else if (wait_left > 0)
                wait_left--;
            m_tready <= (wait_left == 0);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int               r;
        int               s;
        logic             op;
        logic [REQ_W-1:0] req;
        logic [OFF_W-1:0] off;

        // Error rows and a few states that are plain to see have their results typed in.
        directed_rows = '{
            '{OP_ALLOC, 16'd0,     12'd0,    1'b1, '{ST_ZERO,      12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd65535, 12'd0,    1'b1, '{ST_TOO_LARGE, 12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd4089,  12'd0,    1'b1, '{ST_TOO_LARGE, 12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd0,    1'b1, '{ST_NOT_ALLOC, 12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd8,    1'b1, '{ST_NOT_ALLOC, 12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'hffff,  12'd4095, 1'b1, '{ST_NOT_ALLOC, 12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd12,   1'b1, '{ST_NOT_ALLOC, 12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd4088,  12'hfff,  1'b1, '{ST_OK,        12'd8, 12'd4088, 9'd1}},
            '{OP_ALLOC, 16'd1,     12'd0,    1'b1, '{ST_NO_FIT,    12'd0, 12'd4088, 9'd1}},
            '{OP_FREE,  16'd0,     12'd8,    1'b1, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd4080,  12'd0,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd8,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd1,     12'd0,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd100,   12'd0,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd24,    12'd0,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd16,   1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd8,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd8,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd8,     12'd0,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd24,   1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd136,  1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd8,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_ALLOC, 16'd4088,  12'd0,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}},
            '{OP_FREE,  16'd0,     12'd8,    1'b0, '{ST_OK,        12'd0, 12'd0,    9'd0}}
        };

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        items_sent = 0;
        for (int g = 0; g < GRANULES; g++)
        begin
            chunk_used[g] = 1'b0;
            chunk_gran[g] = 0;
        end
        chunk_gran[0]    = GRANULES - 1;
        live_byte_total  = 0;
        live_chunk_total = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < ROWS; i++)
            send_item(directed_rows[i].op, directed_rows[i].req, directed_rows[i].off,
                      directed_rows[i].typed, directed_rows[i].res);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == PAUSE_AT)
            begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            r   = $urandom_range(0, 99);
            s   = $urandom_range(0, 99);
            req = $urandom_range(0, 65535);
            off = $urandom_range(0, 4095);
            if (live_chunk_total == 0)
                op = (r < 90) ? OP_ALLOC : OP_FREE;
            else if (live_byte_total > 3500 || live_chunk_total > 40)
                op = (r < 30) ? OP_ALLOC : OP_FREE;
            else
                op = (r < 60) ? OP_ALLOC : OP_FREE;
            if (op == OP_ALLOC)
            begin
                if (s < 55)
                    req = $urandom_range(1, 128);
                else if (s < 80)
                    req = $urandom_range(129, 512);
                else if (s < 90)
                    req = $urandom_range(513, 2048);
                else if (s < 94)
                    req = $urandom_range(2049, 4088);
                else if (s < 96)
                    req = '0;
                else if (s < 98)
                    req = $urandom_range(4089, 65535);
            end
            else
            begin
                if (s < 80)
                    off = pick_chunk(1'b1);
                else if (s < 88)
                    off = pick_chunk(1'b0);
                else if (s < 93)
                    off = pick_chunk(1'b1) + OFF_W'($urandom_range(1, 7));
                else if (s < 96)
                    off = '0;
            end
            send_item(op, req, off, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### first_fit_heap_allocator.f
hdl/ffha_pkg.sv
hdl/first_fit_heap_allocator.sv
hdl/ffha_checker.sv
test/tb_first_fit_heap_allocator.sv
